/* hdl/triangle_min_angle_check_assert.svh */
// Assertion macros for the triangle minimum-angle check RTL.
// Both macros sample on clk and are disabled while rst is high.
// Define NO_ASSERTIONS to compile them away.
`ifndef TRIANGLE_MIN_ANGLE_CHECK_ASSERT_SVH
`define TRIANGLE_MIN_ANGLE_CHECK_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define TMAC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define TMAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TMAC_ASSERT_NOW(label, ante, cons, msg)
`define TMAC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* hdl/tmac_pkg.sv */
// Types, widths and codes for the triangle minimum-angle check.
// No dependencies; used by tmac_angle and triangle_min_angle_check.
`timescale 1ns / 1ps

package tmac_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_W     = COORD_BITS + 1;       // edge vector component
  localparam int PROD_W     = 2 * COORD_BITS + 2;   // component product
  localparam int DOT_W      = 2 * COORD_BITS + 3;   // signed dot product
  localparam int SQ_W       = 2 * COORD_BITS + 2;   // squared length, positive dot
  localparam int HALF_W     = SQ_W / 2;             // multiplier operand slice
  localparam int SQSQ_W     = 2 * SQ_W;             // product of two squared terms
  localparam int COS_W      = 32;                   // Q0.32 threshold
  localparam int CMP_W      = SQSQ_W + COS_W;       // both sides of the compare
  localparam int SLICES     = SQSQ_W / HALF_W;      // slices of s2*t2 scaled by cos
  localparam int STAGES     = 9;

  localparam logic [COS_W-1:0] COS_SQ_RESET = 32'd4283203200;

  typedef enum logic [1:0] {
    CAUSE_OK          = 2'd0,
    CAUSE_ZERO_SIDE   = 2'd1,
    CAUSE_SMALL_ANGLE = 2'd2
  } cause_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] p1_x;
    logic signed [COORD_BITS-1:0] p1_y;
    logic signed [COORD_BITS-1:0] p1_z;
    logic signed [COORD_BITS-1:0] p2_x;
    logic signed [COORD_BITS-1:0] p2_y;
    logic signed [COORD_BITS-1:0] p2_z;
    logic signed [COORD_BITS-1:0] p3_x;
    logic signed [COORD_BITS-1:0] p3_y;
    logic signed [COORD_BITS-1:0] p3_z;
  } tri_t;

  typedef struct packed {
    logic   degenerate;
    cause_t cause;
  } verdict_t;

  // load enables of the angle test stages
  typedef struct packed {
    logic pp;      // partial products of d^2 and s2*t2
    logic merge;   // combine partial products
    logic scale;   // slices of s2*t2 times threshold
    logic acc;     // accumulate the scaled slices
    logic cmp;     // final compare
  } angle_en_t;

endpackage

/* hdl/triangle_min_angle_check.sv */
// Top level of the triangle minimum-angle check: edge vectors, dot products, verdict.
// Depends on tmac_pkg, tmac_angle and triangle_min_angle_check_assert.svh.
//
//   channel  | signals                       | beat
//   ---------+-------------------------------+-----------------------------------
//   item     | item, item_valid, item_stall  | one triangle (tri_t)
//   result   | result, result_valid, result_stall | one verdict (verdict_t)
//   config   | cfg_we, cfg_wdata             | threshold write, one cycle
//
// Nine register stages; one triangle enters per cycle while item_stall is low.
// The multiplier slices of the wide s2*t2*cos product set the stage count.
// Reset clears all stage valid bits and loads the threshold near 3 degrees.
// A stage advances when it is empty or the stage after it advances, so
// bubbles close up under a stall and item_stall rises only when all are full.
`timescale 1ns / 1ps
`include "triangle_min_angle_check_assert.svh"

module triangle_min_angle_check (
  input  logic                         clk,
  input  logic                         rst,
  input  tmac_pkg::tri_t               item,
  input  logic                         item_valid,
  output logic                         item_stall,
  output tmac_pkg::verdict_t           result,
  output logic                         result_valid,
  input  logic                         result_stall,
  input  logic                         cfg_we,
  input  logic [tmac_pkg::COS_W-1:0]   cfg_wdata
);

  localparam int NST = tmac_pkg::STAGES;
  localparam int DF  = tmac_pkg::DIFF_W;
  localparam int PR  = tmac_pkg::PROD_W;
  localparam int DT  = tmac_pkg::DOT_W;
  localparam int SW  = tmac_pkg::SQ_W;

  logic [tmac_pkg::COS_W-1:0] cos_sq;
  logic [NST-1:0]             vld;
  logic [NST-1:0]             ready;

  logic signed [tmac_pkg::COORD_BITS-1:0] pt [9];
  logic signed [DF-1:0] diff_next [9];
  logic signed [DF-1:0] diff [9];      // a = p2-p1, b = p3-p1, c = p3-p2
  logic signed [PR-1:0] sq [9];
  logic signed [PR-1:0] dt [9];        // a.b, a.c, b.c terms
  logic signed [DT-1:0] len_sum [3];
  logic signed [DT-1:0] dot_sum [3];
  logic [SW-1:0]        a2, b2, c2;
  logic                 dpos [3];
  logic [SW-1:0]        dmag [3];
  logic                 zero [2:7];
  logic [2:0]           sharp;
  tmac_pkg::angle_en_t  angle_en;
  tmac_pkg::verdict_t   verdict;

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_sq <= tmac_pkg::COS_SQ_RESET;
    end else if (cfg_we) begin
      cos_sq <= cfg_wdata;
    end
  end

  // stage handshake
  always_comb begin
    ready[NST-1] = !vld[NST-1] || !result_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      ready[k] = !vld[k] || ready[k+1];
    end
  end

  assign item_stall   = !ready[0];
  assign result_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ready[0]) begin
        vld[0] <= item_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (ready[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // stage 0: edge vectors
  assign pt[0] = item.p1_x;
  assign pt[1] = item.p1_y;
  assign pt[2] = item.p1_z;
  assign pt[3] = item.p2_x;
  assign pt[4] = item.p2_y;
  assign pt[5] = item.p2_z;
  assign pt[6] = item.p3_x;
  assign pt[7] = item.p3_y;
  assign pt[8] = item.p3_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff_next[i]   = DF'(pt[3+i]) - DF'(pt[i]);
      diff_next[3+i] = DF'(pt[6+i]) - DF'(pt[i]);
      diff_next[6+i] = DF'(pt[6+i]) - DF'(pt[3+i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ready[0]) begin
      diff <= diff_next;
    end
  end

  // stage 1: component products
  always_ff @(posedge clk) begin
    if (ready[1]) begin
      for (int i = 0; i < 9; i++) begin
        sq[i] <= PR'(diff[i]) * PR'(diff[i]);
      end
      for (int i = 0; i < 3; i++) begin
        dt[i]   <= PR'(diff[i])   * PR'(diff[3+i]);
        dt[3+i] <= PR'(diff[i])   * PR'(diff[6+i]);
        dt[6+i] <= PR'(diff[3+i]) * PR'(diff[6+i]);
      end
    end
  end

  // stage 2: squared lengths and the dot product at each vertex
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      len_sum[j] = DT'(sq[3*j]) + DT'(sq[3*j+1]) + DT'(sq[3*j+2]);
    end
    dot_sum[0] = DT'(dt[0]) + DT'(dt[1]) + DT'(dt[2]);
    dot_sum[1] = -(DT'(dt[3]) + DT'(dt[4]) + DT'(dt[5]));
    dot_sum[2] = DT'(dt[6]) + DT'(dt[7]) + DT'(dt[8]);
  end

  always_ff @(posedge clk) begin
    if (ready[2]) begin
      a2      <= len_sum[0][SW-1:0];
      b2      <= len_sum[1][SW-1:0];
      c2      <= len_sum[2][SW-1:0];
      for (int j = 0; j < 3; j++) begin
        dpos[j] <= !dot_sum[j][DT-1] && (dot_sum[j] != '0);
        dmag[j] <= dot_sum[j][SW-1:0];
      end
    end
  end

  // zero-side flag, carried alongside the angle tests
  always_ff @(posedge clk) begin
    if (ready[2]) begin
      zero[2] <= (len_sum[0] == '0) || (len_sum[1] == '0) || (len_sum[2] == '0);
    end
    for (int k = 3; k <= 7; k++) begin
      if (ready[k]) begin
        zero[k] <= zero[k-1];
      end
    end
  end

  // stages 3 to 7: angle tests
  assign angle_en.pp    = ready[3];
  assign angle_en.merge = ready[4];
  assign angle_en.scale = ready[5];
  assign angle_en.acc   = ready[6];
  assign angle_en.cmp   = ready[7];

  tmac_angle u_angle_p1 (
    .clk    (clk),
    .en     (angle_en),
    .dpos   (dpos[0]),
    .dmag   (dmag[0]),
    .s2     (a2),
    .t2     (b2),
    .cos_sq (cos_sq),
    .sharp  (sharp[0])
  );

  tmac_angle u_angle_p2 (
    .clk    (clk),
    .en     (angle_en),
    .dpos   (dpos[1]),
    .dmag   (dmag[1]),
    .s2     (a2),
    .t2     (c2),
    .cos_sq (cos_sq),
    .sharp  (sharp[1])
  );

  tmac_angle u_angle_p3 (
    .clk    (clk),
    .en     (angle_en),
    .dpos   (dpos[2]),
    .dmag   (dmag[2]),
    .s2     (b2),
    .t2     (c2),
    .cos_sq (cos_sq),
    .sharp  (sharp[2])
  );

  // stage 8: verdict, zero-length side wins over angle
  always_comb begin
    if (zero[7]) begin
      verdict.degenerate = 1'b1;
      verdict.cause      = tmac_pkg::CAUSE_ZERO_SIDE;
    end else if (|sharp) begin
      verdict.degenerate = 1'b1;
      verdict.cause      = tmac_pkg::CAUSE_SMALL_ANGLE;
    end else begin
      verdict.degenerate = 1'b0;
      verdict.cause      = tmac_pkg::CAUSE_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (ready[NST-1]) begin
      result <= verdict;
    end
  end

  `TMAC_ASSERT_NOW(a_flag_matches_cause, result_valid,
    result.degenerate == (result.cause != tmac_pkg::CAUSE_OK), "degenerate disagrees with cause")
  `TMAC_ASSERT_NOW(a_stall_only_when_full, item_stall, &vld,
    "input stalled while a stage is empty")
  `TMAC_ASSERT_NOW(a_empty_after_reset, $past(rst), !result_valid,
    "result valid right after reset")

endmodule

/* hdl/tmac_angle.sv */
// One vertex angle test: d^2 * 2^32 > cos_sq * s2 * t2 with d > 0, over five stages.
// Depends on tmac_pkg; instanced three times by triangle_min_angle_check.
`timescale 1ns / 1ps

module tmac_angle (
  input  logic                             clk,
  input  tmac_pkg::angle_en_t              en,
  input  logic                             dpos,
  input  logic [tmac_pkg::SQ_W-1:0]        dmag,
  input  logic [tmac_pkg::SQ_W-1:0]        s2,
  input  logic [tmac_pkg::SQ_W-1:0]        t2,
  input  logic [tmac_pkg::COS_W-1:0]       cos_sq,
  output logic                             sharp
);

  localparam int H   = tmac_pkg::HALF_W;
  localparam int SW  = tmac_pkg::SQ_W;
  localparam int PW  = tmac_pkg::SQSQ_W;
  localparam int CW  = tmac_pkg::COS_W;
  localparam int XW  = tmac_pkg::CMP_W;
  localparam int NS  = tmac_pkg::SLICES;
  localparam int PPW = 2 * H;
  localparam int SCW = H + CW;

  // partial products
  logic          dpos_pp;
  logic [2*H-1:0] dhh, dhl, dll;
  logic [2*H-1:0] shh, shl, slh, sll;

  // merged
  logic          dpos_mg;
  logic [PW-1:0] dsq_mg;
  logic [PW-1:0] st_mg;

  // scaled slices
  logic          dpos_sc;
  logic [PW-1:0] dsq_sc;
  logic [H+CW-1:0] scaled [NS];

  // accumulated
  logic          dpos_ac;
  logic [PW-1:0] dsq_ac;
  logic [XW-1:0] rhs_ac;
  logic [XW-1:0] rhs_next;

  always_ff @(posedge clk) begin
    if (en.pp) begin
      dpos_pp <= dpos;
      dhh     <= PPW'(dmag[SW-1:H]) * PPW'(dmag[SW-1:H]);
      dhl     <= PPW'(dmag[SW-1:H]) * PPW'(dmag[H-1:0]);
      dll     <= PPW'(dmag[H-1:0])  * PPW'(dmag[H-1:0]);
      shh     <= PPW'(s2[SW-1:H])   * PPW'(t2[SW-1:H]);
      shl     <= PPW'(s2[SW-1:H])   * PPW'(t2[H-1:0]);
      slh     <= PPW'(s2[H-1:0])    * PPW'(t2[SW-1:H]);
      sll     <= PPW'(s2[H-1:0])    * PPW'(t2[H-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en.merge) begin
      dpos_mg <= dpos_pp;
      // cross term appears twice in the square
      dsq_mg  <= (PW'(dhh) << (2 * H)) + (PW'(dhl) << (H + 1)) + PW'(dll);
      st_mg   <= (PW'(shh) << (2 * H)) + ((PW'(shl) + PW'(slh)) << H) + PW'(sll);
    end
  end

  always_ff @(posedge clk) begin
    if (en.scale) begin
      dpos_sc <= dpos_mg;
      dsq_sc  <= dsq_mg;
      for (int i = 0; i < NS; i++) begin
        scaled[i] <= SCW'(st_mg[i*H +: H]) * SCW'(cos_sq);
      end
    end
  end

  always_comb begin
    rhs_next = '0;
    for (int i = 0; i < NS; i++) begin
      rhs_next = rhs_next + (XW'(scaled[i]) << (i * H));
    end
  end

  always_ff @(posedge clk) begin
    if (en.acc) begin
      dpos_ac <= dpos_sc;
      dsq_ac  <= dsq_sc;
      rhs_ac  <= rhs_next;
    end
  end

  // equality passes
  always_ff @(posedge clk) begin
    if (en.cmp) begin
      sharp <= dpos_ac && ({dsq_ac, {CW{1'b0}}} > rhs_ac);
    end
  end

endmodule

/* dv/tmac_verdict_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for triangle_min_angle_check: predicts the verdict of each triangle beat.
// Compares it with the result beats in order. Depends on tmac_pkg.

module tmac_verdict_checker
  import tmac_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  tri_t             item,
  input  logic             item_valid,
  input  logic             item_stall,
  input  verdict_t         result,
  input  logic             result_valid,
  input  logic             result_stall,
  input  logic             cfg_we,
  input  logic [COS_W-1:0] cfg_wdata,
  output int               mismatch_count,
  output int               verdicts_pending
);

  logic [COS_W-1:0] cos_sq_limit;
  verdict_t         expected_verdicts[$];

  // d^2 * 2^32 > cos^2 * s2 * t2, only for a positive dot product
  function automatic bit angle_too_sharp(longint d, longint s2, longint t2,
                                         logic [COS_W-1:0] cos_sq);
    logic [127:0] dw, sw, tw, cw, lhs, rhs;
    if (d <= 0) return 1'b0;
    dw = 128'(d);
    sw = 128'(s2);
    tw = 128'(t2);
    cw = 128'(cos_sq);
    lhs = (dw * dw) << 32;
    rhs = sw * tw * cw;
    return lhs > rhs;
  endfunction

  function automatic verdict_t judge_triangle(tri_t t, logic [COS_W-1:0] cos_sq);
    longint ax, ay, az, bx, by, bz, cx, cy, cz;
    longint a2, b2, c2, d1, d2, d3;
    verdict_t v;
    ax = longint'($signed(t.p2_x)) - longint'($signed(t.p1_x));
    ay = longint'($signed(t.p2_y)) - longint'($signed(t.p1_y));
    az = longint'($signed(t.p2_z)) - longint'($signed(t.p1_z));
    bx = longint'($signed(t.p3_x)) - longint'($signed(t.p1_x));
    by = longint'($signed(t.p3_y)) - longint'($signed(t.p1_y));
    bz = longint'($signed(t.p3_z)) - longint'($signed(t.p1_z));
    cx = longint'($signed(t.p3_x)) - longint'($signed(t.p2_x));
    cy = longint'($signed(t.p3_y)) - longint'($signed(t.p2_y));
    cz = longint'($signed(t.p3_z)) - longint'($signed(t.p2_z));
    a2 = ax * ax + ay * ay + az * az;
    b2 = bx * bx + by * by + bz * bz;
    c2 = cx * cx + cy * cy + cz * cz;
    if (a2 == 0 || b2 == 0 || c2 == 0) begin
      v.degenerate = 1'b1;
      v.cause      = CAUSE_ZERO_SIDE;
      return v;
    end
    // dot product of the edges that leave each vertex
    d1 = ax * bx + ay * by + az * bz;
    d2 = -(ax * cx + ay * cy + az * cz);
    d3 = bx * cx + by * cy + bz * cz;
    if (angle_too_sharp(d1, a2, b2, cos_sq) || angle_too_sharp(d2, a2, c2, cos_sq) ||
        angle_too_sharp(d3, b2, c2, cos_sq)) begin
      v.degenerate = 1'b1;
      v.cause      = CAUSE_SMALL_ANGLE;
    end else begin
      v.degenerate = 1'b0;
      v.cause      = CAUSE_OK;
    end
    return v;
  endfunction

  always @(posedge clk) begin : watch
    verdict_t want;
    int       errs;
    errs = 0;
    if (rst) begin
      cos_sq_limit <= COS_SQ_RESET;
      expected_verdicts.delete();
      mismatch_count   <= 0;
      verdicts_pending <= 0;
    end else begin
      if (cfg_we) cos_sq_limit <= cfg_wdata;
      // pop before push: a beat never leaves in the cycle it enters
      if (result_valid && !result_stall) begin
        if (expected_verdicts.size() == 0) begin
          $error("result beat with no triangle outstanding: degenerate %0b cause %0d",
                 result.degenerate, result.cause);
          errs++;
        end else begin
          want = expected_verdicts.pop_front();
          if (result.degenerate !== want.degenerate) begin
            $error("degenerate: expected %0b, actual %0b", want.degenerate,
                   result.degenerate);
            errs++;
          end
          if (result.cause !== want.cause) begin
            $error("cause: expected %0d, actual %0d", want.cause, result.cause);
            errs++;
          end
        end
      end
      if (item_valid && !item_stall)
        expected_verdicts.push_back(judge_triangle(item, cos_sq_limit));
      mismatch_count   <= mismatch_count + errs;
      verdicts_pending <= expected_verdicts.size();
    end
  end

endmodule

/* dv/tb_triangle_min_angle_check.sv */
`timescale 1ns / 1ps
// Testbench top for triangle_min_angle_check: directed and random triangle beats.
// Depends on tmac_pkg, the RTL and tmac_verdict_checker.

module tb_triangle_min_angle_check;
  import tmac_pkg::*;

  localparam int RUN_LIMIT       = 200000;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int PHASES          = 8;
  localparam int PHASE_ITEMS     = 128;
  localparam logic [COS_W-1:0] COS_SQ_45 = 32'h8000_0000;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic             clk;
  logic             rst;
  tri_t             item;
  logic             item_valid;
  logic             item_stall;
  verdict_t         result;
  logic             result_valid;
  logic             result_stall;
  logic             cfg_we;
  logic [COS_W-1:0] cfg_wdata;

  int mismatch_count;
  int verdicts_pending;
  int cycle_count = 0;
  int send_idle_pct;
  int stall_pct;
  bit hold_off_req;
  bit hold_off_done;

  triangle_min_angle_check u_top (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  tmac_verdict_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .item             (item),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .result           (result),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .mismatch_count   (mismatch_count),
    .verdicts_pending (verdicts_pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("triangle_min_angle_check regression: fail");
      $finish;
    end
  end

  // result side: one long hold-off on request, otherwise random stalls
  initial begin
    int held;
    held = 0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        result_stall <= 1'b1;
        held++;
        if (held == HOLD_OFF_CYCLES) hold_off_done = 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic tri_t pack_tri(int x1, int y1, int z1, int x2, int y2, int z2,
                                    int x3, int y3, int z3);
    tri_t t;
    t.p1_x = 16'(x1);
    t.p1_y = 16'(y1);
    t.p1_z = 16'(z1);
    t.p2_x = 16'(x2);
    t.p2_y = 16'(y2);
    t.p2_z = 16'(z2);
    t.p3_x = 16'(x3);
    t.p3_y = 16'(y3);
    t.p3_z = 16'(z3);
    return t;
  endfunction

  function automatic tri_t random_triangle();
    int v[9];
    int w[9];
    int edge_vals[7];
    int sel, span, mult, rot, src, dst, i, base, step, nz;
    edge_vals = '{-32768, -32767, -1, 0, 1, 32766, 32767};
    sel = $urandom_range(99);
    if (sel < 25) begin
      for (i = 0; i < 9; i++) v[i] = $urandom_range(65535);
    end else if (sel < 40) begin
      // tiny box: many repeated vertices and collinear sets
      for (i = 0; i < 9; i++) v[i] = int'($urandom_range(6)) - 3;
    end else if (sel < 70) begin
      // sliver: third vertex near the line through the first two
      span = 1 << $urandom_range(11);
      mult = int'($urandom_range(6)) - 3;
      nz   = $urandom_range(3);
      for (i = 0; i < 3; i++) begin
        base     = int'($urandom_range(32000)) - 16000;
        step     = int'($urandom_range(2 * span)) - span;
        v[i]     = base;
        v[3 + i] = base + step;
        v[6 + i] = base + mult * step + int'($urandom_range(2 * nz)) - nz;
      end
      rot = $urandom_range(2);
      for (i = 0; i < 9; i++) w[i] = v[(i + 3 * rot) % 9];
      v = w;
    end else if (sel < 85) begin
      for (i = 0; i < 9; i++) v[i] = $urandom_range(65535);
      src = $urandom_range(2);
      dst = (src + 1 + $urandom_range(1)) % 3;
      for (i = 0; i < 3; i++) v[3 * dst + i] = v[3 * src + i];
    end else begin
      for (i = 0; i < 9; i++) v[i] = edge_vals[$urandom_range(6)];
    end
    return pack_tri(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]);
  endfunction

  task automatic apply_idling(idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 73;
        stall_pct     = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        stall_pct     = 73;
      end
      default: begin
        send_idle_pct = 15;
        stall_pct     = 15;
      end
    endcase
  endtask

  // enter at a rising edge, leave at the edge that takes the beat
  task automatic send_triangle(tri_t t);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item       <= t;
    item_valid <= 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !item_stall;
      @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    do @(negedge clk); while (verdicts_pending != 0);
    @(posedge clk);
  endtask

  task automatic write_threshold(logic [COS_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int phase, n;
    rst        <= 1'b1;
    item       <= '0;
    item_valid <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    apply_idling(IDLE_NONE);
    hold_off_req = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed beats at the reset threshold
    send_triangle(pack_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_triangle(pack_tri(-32768, -32768, -32768, -32768, -32768, -32768,
                           -32768, -32768, -32768));
    send_triangle(pack_tri(32767, 32767, 32767, 32767, 32767, 32767,
                           32767, 32767, 32767));
    send_triangle(pack_tri(5, 5, 5, 5, 5, 5, 9, -3, 2));
    send_triangle(pack_tri(0, 0, 0, -32768, 32767, -1, -32768, 32767, -1));
    send_triangle(pack_tri(32767, -32768, 0, 1, 2, 3, 32767, -32768, 0));
    send_triangle(pack_tri(0, 0, 0, 1, 1, 1, 2, 2, 2));
    send_triangle(pack_tri(-32767, -32767, -32767, 0, 0, 0, 32767, 32767, 32767));
    send_triangle(pack_tri(-32768, 0, 0, 32767, 0, 0, 0, 0, 0));
    send_triangle(pack_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
    send_triangle(pack_tri(-32768, -32768, -32768, 32767, 32767, -32768,
                           32767, -32768, 32767));
    send_triangle(pack_tri(32767, 32767, 32767, -32768, -32768, 32767,
                           -32768, 32767, -32768));
    send_triangle(pack_tri(0, 0, 0, 1000, 0, 0, 0, 1, 0));
    send_triangle(pack_tri(0, 0, 0, 1000, 0, 0, 1000, 52, 0));
    send_triangle(pack_tri(0, 0, 0, 1000, 0, 0, 1000, 53, 0));
    send_triangle(pack_tri(21845, -21846, 21845, -21846, 21845, -21846,
                           21845, 21845, -21846));
    send_triangle(pack_tri(-1, -1, -1, -32768, -1, -1, -1, -32768, -1));
    wait_drained();

    // 45 degree corner: exactly at the limit, then just past it
    write_threshold(COS_SQ_45);
    send_triangle(pack_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
    send_triangle(pack_tri(7, -3, 2, 7, 5, 2, -1, -3, 2));
    wait_drained();
    write_threshold(COS_SQ_45 - 1);
    send_triangle(pack_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
    wait_drained();
    // zero threshold flags every triangle with nonzero sides
    write_threshold('0);
    send_triangle(pack_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
    send_triangle(pack_tri(-32768, -32768, -32768, 32767, 32767, -32768,
                           32767, -32768, 32767));
    wait_drained();

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: write_threshold(COS_SQ_RESET);
        1: write_threshold('0);
        2: write_threshold('1);
        3: write_threshold(32'hC000_0000);
        4: write_threshold(COS_SQ_45);
        5: write_threshold(32'hFFF0_0000);
        6: write_threshold($urandom);
        default: write_threshold(32'hFFFF_FFFE);
      endcase
      apply_idling(idle_mode_e'(phase % 4));
      // fill the pipe against a held-off receiver once
      if (phase == 0) hold_off_req = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) send_triangle(random_triangle());
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0)
      $display("triangle_min_angle_check regression: pass");
    else
      $display("triangle_min_angle_check regression: fail");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/tmac_pkg.sv
hdl/tmac_angle.sv
hdl/triangle_min_angle_check.sv
dv/tmac_verdict_checker.sv
dv/tb_triangle_min_angle_check.sv
